[rtl/cwlw_pkg.sv]
// ----------------------------------------------------------------------------
// cwlw_pkg
// Shared types, constants and functions of the cell-width line wrapper:
// cell width classification and UTF-8 byte generation.
// ----------------------------------------------------------------------------
package cwlw_pkg;

    // cell width classes
    localparam logic [1:0] W_ZERO = 2'd0;
    localparam logic [1:0] W_NEG  = 2'd1;
    localparam logic [1:0] W_ONE  = 2'd2;
    localparam logic [1:0] W_TWO  = 2'd3;

    // register map
    localparam logic REG_IDX_LINE_WIDTH = 1'b0;
    localparam logic [11:0] LINE_WIDTH_RESET = 12'd80;

    // byte constants
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] CONT_BYTE    = 8'h80;
    localparam logic [7:0] LEAD_2       = 8'hC0;
    localparam logic [7:0] LEAD_3       = 8'hE0;
    localparam logic [7:0] LEAD_4       = 8'hF0;
    localparam logic [7:0] LEAD_5       = 8'hF8;
    localparam logic [7:0] LEAD_6       = 8'hFC;

    // signed count limits
    localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] COUNT_MIN = -16'sh8000;

    // entry handed from the front to the back
    typedef struct packed {
        logic [30:0] cp;
        logic        nl;
        logic [2:0]  len;
    } cwlw_entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } cwlw_qstat_t;

    // combining intervals, {low, high}
    localparam int ZW_COUNT = 92;
    localparam logic [31:0] ZW_TAB [ZW_COUNT] = '{
        32'h0300_034E, 32'h0360_0362, 32'h0483_0486, 32'h0488_0489,
        32'h0591_05A1, 32'h05A3_05B9, 32'h05BB_05BD, 32'h05BF_05BF,
        32'h05C1_05C2, 32'h05C4_05C4, 32'h064B_0655, 32'h0670_0670,
        32'h06D6_06E4, 32'h06E7_06E8, 32'h06EA_06ED, 32'h0711_0711,
        32'h0730_074A, 32'h07A6_07B0, 32'h0901_0902, 32'h093C_093C,
        32'h0941_0948, 32'h094D_094D, 32'h0951_0954, 32'h0962_0963,
        32'h0981_0981, 32'h09BC_09BC, 32'h09C1_09C4, 32'h09CD_09CD,
        32'h09E2_09E3, 32'h0A02_0A02, 32'h0A3C_0A3C, 32'h0A41_0A42,
        32'h0A47_0A48, 32'h0A4B_0A4D, 32'h0A70_0A71, 32'h0A81_0A82,
        32'h0ABC_0ABC, 32'h0AC1_0AC5, 32'h0AC7_0AC8, 32'h0ACD_0ACD,
        32'h0B01_0B01, 32'h0B3C_0B3C, 32'h0B3F_0B3F, 32'h0B41_0B43,
        32'h0B4D_0B4D, 32'h0B56_0B56, 32'h0B82_0B82, 32'h0BC0_0BC0,
        32'h0BCD_0BCD, 32'h0C3E_0C40, 32'h0C46_0C48, 32'h0C4A_0C4D,
        32'h0C55_0C56, 32'h0CBF_0CBF, 32'h0CC6_0CC6, 32'h0CCC_0CCD,
        32'h0D41_0D43, 32'h0D4D_0D4D, 32'h0DCA_0DCA, 32'h0DD2_0DD4,
        32'h0DD6_0DD6, 32'h0E31_0E31, 32'h0E34_0E3A, 32'h0E47_0E4E,
        32'h0EB1_0EB1, 32'h0EB4_0EB9, 32'h0EBB_0EBC, 32'h0EC8_0ECD,
        32'h0F18_0F19, 32'h0F35_0F35, 32'h0F37_0F37, 32'h0F39_0F39,
        32'h0F71_0F7E, 32'h0F80_0F84, 32'h0F86_0F87, 32'h0F90_0F97,
        32'h0F99_0FBC, 32'h0FC6_0FC6, 32'h102D_1030, 32'h1032_1032,
        32'h1036_1037, 32'h1039_1039, 32'h1058_1059, 32'h17B7_17BD,
        32'h17C6_17C6, 32'h17C9_17D3, 32'h18A9_18A9, 32'h20D0_20E3,
        32'h302A_302F, 32'h3099_309A, 32'hFB1E_FB1E, 32'hFE20_FE23
    };

    // terminal cell width class of a code point
    function automatic logic [1:0] cell_class(input logic [30:0] cp);
        logic        low16;
        logic        zw;
        logic        wide;
        logic [15:0] c;
        low16 = (cp[30:16] == 15'd0);
        c     = cp[15:0];
        zw    = 1'b0;
        for (int i = 0; i < ZW_COUNT; i++)
        begin
            if (c >= ZW_TAB[i][31:16] && c <= ZW_TAB[i][15:0])
            begin
                zw = 1'b1;
            end
        end
        wide = low16 && (
            (c >= 16'h1100 && c <= 16'h115F) ||
            (c >= 16'h2E80 && c <= 16'hA4CF &&
             (c & 16'hFFEE) != 16'h300A && c != 16'h303F) ||
            (c >= 16'hAC00 && c <= 16'hD7A3) ||
            (c >= 16'hF900 && c <= 16'hFAFF) ||
            (c >= 16'hFE30 && c <= 16'hFE6F) ||
            (c >= 16'hFF00 && c <= 16'hFF5F) ||
            (c >= 16'hFFE0 && c <= 16'hFFE6));
        if (cp == 31'd0)
        begin
            return W_ZERO;
        end
        else if (cp < 31'h20 || (cp >= 31'h7F && cp < 31'hA0))
        begin
            return W_NEG;
        end
        else if (low16 && zw)
        begin
            return W_ZERO;
        end
        else if (wide)
        begin
            return W_TWO;
        end
        return W_ONE;
    endfunction

    // number of UTF-8 bytes of a code point
    function automatic logic [2:0] utf8_len(input logic [30:0] cp);
        if (cp < 31'h80)
        begin
            return 3'd1;
        end
        else if (cp < 31'h800)
        begin
            return 3'd2;
        end
        else if (cp < 31'h10000)
        begin
            return 3'd3;
        end
        else if (cp < 31'h200000)
        begin
            return 3'd4;
        end
        else if (cp < 31'h4000000)
        begin
            return 3'd5;
        end
        return 3'd6;
    endfunction

    // byte k of the UTF-8 encoding of cp, which is len bytes long
    function automatic logic [7:0] utf8_byte(
        input logic [30:0] cp,
        input logic [2:0]  len,
        input logic [2:0]  k
    );
        logic [37:0] ext;
        logic [2:0]  m;
        logic [7:0]  slice;
        logic [7:0]  lead;
        ext = {7'd0, cp};
        m   = len - 3'd1 - k;
        case (m)
            3'd0:    slice = ext[7:0];
            3'd1:    slice = ext[13:6];
            3'd2:    slice = ext[19:12];
            3'd3:    slice = ext[25:18];
            3'd4:    slice = ext[31:24];
            3'd5:    slice = ext[37:30];
            default: slice = 8'd0;
        endcase
        case (len)
            3'd2:    lead = LEAD_2;
            3'd3:    lead = LEAD_3;
            3'd4:    lead = LEAD_4;
            3'd5:    lead = LEAD_5;
            3'd6:    lead = LEAD_6;
            default: lead = 8'd0;
        endcase
        if (len == 3'd1)
        begin
            return {1'b0, cp[6:0]};
        end
        else if (k == 3'd0)
        begin
            return lead | slice;
        end
        return CONT_BYTE | {2'b00, slice[5:0]};
    endfunction

endpackage

[rtl/cwlw_front.sv]
// ----------------------------------------------------------------------------
// cwlw_front
// Accepts code points, classifies cell width in a first stage, then updates
// the running cell count, decides on an inserted newline and queues the item.
// ----------------------------------------------------------------------------
module cwlw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [30:0]          code_point,
    input  logic [11:0]          line_width,
    input  cwlw_pkg::cwlw_qstat_t qstat,
    output logic                 q_push,
    output cwlw_pkg::cwlw_entry_t q_data
);
    import cwlw_pkg::*;

    logic              a_valid_reg;
    logic              a_valid_next;
    logic [30:0]       a_cp_reg;
    logic [1:0]        a_class_reg;
    logic signed [15:0] count_reg;
    logic signed [15:0] count_next;
    logic signed [16:0] delta;
    logic signed [16:0] sum;
    logic signed [15:0] sat;
    logic              accept;
    logic              wrap;

    // input transfer and stage handoff
    assign full   = a_valid_reg && qstat.full;
    assign accept = push && !full;
    assign q_push = a_valid_reg && !qstat.full;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            a_valid_next = 1'b0;
        end
    end

    // width as a signed step
    always_comb
    begin
        case (a_class_reg)
            W_NEG:   delta = -17'sd1;
            W_ONE:   delta = 17'sd1;
            W_TWO:   delta = 17'sd2;
            default: delta = 17'sd0;
        endcase
    end

    // saturating count update, newline clear and wrap decision
    always_comb
    begin
        sum = {count_reg[15], count_reg} + delta;
        if (sum > 17'sd32767)
        begin
            sat = COUNT_MAX;
        end
        else if (sum < -17'sd32768)
        begin
            sat = COUNT_MIN;
        end
        else
        begin
            sat = sum[15:0];
        end
        if (a_cp_reg == {23'd0, NEWLINE_BYTE})
        begin
            sat = 16'sd0;
        end
        wrap = !sat[15] && (sat[14:0] > {3'd0, line_width});
        count_next = count_reg;
        if (q_push)
        begin
            count_next = wrap ? 16'sd0 : sat;
        end
    end

    assign q_data.cp  = a_cp_reg;
    assign q_data.nl  = wrap;
    assign q_data.len = utf8_len(a_cp_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            count_reg   <= 16'sd0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            count_reg   <= count_next;
        end
    end

    // classify stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_cp_reg    <= code_point;
            a_class_reg <= cell_class(code_point);
        end
    end

endmodule

[rtl/cwlw_queue.sv]
// ----------------------------------------------------------------------------
// cwlw_queue
// Short register queue that decouples the classifying front from the byte
// emitting back.
// ----------------------------------------------------------------------------
module cwlw_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  cwlw_pkg::cwlw_entry_t wr_data,
    input  logic                  rd,
    output cwlw_pkg::cwlw_entry_t rd_data,
    output cwlw_pkg::cwlw_qstat_t qstat
);
    import cwlw_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cwlw_entry_t      slot_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign qstat.full  = (cnt_reg == FULL_CNT);
    assign qstat.empty = (cnt_reg == '0);
    assign do_wr = wr && !qstat.full;
    assign do_rd = rd && !qstat.empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/cwlw_back.sv]
// ----------------------------------------------------------------------------
// cwlw_back
// Walks the queue head byte by byte (optional newline, then UTF-8) into an
// output register that the receiver drains one byte per transfer.
// ----------------------------------------------------------------------------
module cwlw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cwlw_pkg::cwlw_entry_t q_data,
    input  cwlw_pkg::cwlw_qstat_t qstat,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            out_byte,
    output logic                  last_of_item
);
    import cwlw_pkg::*;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [2:0] total;
    logic [2:0] k;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       load;
    logic       emit;

    // byte at the current position of the head entry
    assign total    = q_data.len + {2'd0, q_data.nl};
    assign k        = idx_reg - {2'd0, q_data.nl};
    assign cur_last = (idx_reg == total - 3'd1);
    assign cur_byte = (q_data.nl && idx_reg == 3'd0)
                    ? NEWLINE_BYTE : utf8_byte(q_data.cp, q_data.len, k);

    // output register refills when free or being drained
    assign load  = !out_valid_reg || pop;
    assign emit  = load && !qstat.empty;
    assign q_pop = emit && cur_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = !qstat.empty;
        end
        if (emit)
        begin
            idx_next = cur_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = byte_reg;
    assign last_of_item = last_reg;

endmodule

[rtl/utf8_cell_width_line_wrap_top.sv]
// ----------------------------------------------------------------------------
// utf8_cell_width_line_wrap_top
// Cell-width line wrapper: code points in, UTF-8 bytes out, with a newline
// inserted when the running cell count passes the configured line width.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive code_point and push; a transfer happens on an
//   edge with push high and full low. Items may follow every cycle.
//   Output queue side: while empty is low, out_byte and last_of_item show the
//   oldest byte; it is taken on an edge with pop high. last_of_item marks the
//   final byte caused by one code point.
//   Each code point yields 1 to 7 bytes (an optional inserted newline, then
//   1 to 6 UTF-8 bytes). The byte serializer sends one byte per cycle while
//   the receiver keeps popping, so ASCII text without inserted newlines runs
//   at one item per cycle. The first byte of an item passes the classify
//   stage, then a queue slot and the serializer's output register, before it
//   is on the outputs.
//   When the receiver stalls, the output register holds its byte, the queue
//   fills, and full rises once the classify stage cannot hand off.
//   Reset clears the cell count, the queue and the output register, and sets
//   line_width to 80. line_width is written over the APB port at address 0
//   and should only change while the block is idle.
// ----------------------------------------------------------------------------
module utf8_cell_width_line_wrap_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [30:0] code_point,
    // output queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last_of_item,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cwlw_pkg::*;

    logic        [11:0] line_width_reg;
    logic        [11:0] line_width_next;
    logic               cfg_wr;
    cwlw_qstat_t        qstat;
    cwlw_entry_t        q_wr_data;
    cwlw_entry_t        q_rd_data;
    logic               q_push;
    logic               q_pop;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        line_width_next = line_width_reg;
        if (cfg_wr && paddr[2] == REG_IDX_LINE_WIDTH)
        begin
            line_width_next = pwdata[11:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else
        begin
            line_width_reg <= line_width_next;
        end
    end

    assign prdata = (paddr[2] == REG_IDX_LINE_WIDTH) ? {20'd0, line_width_reg} : 32'd0;

    // front: classify and count
    cwlw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .code_point (code_point),
        .line_width (line_width_reg),
        .qstat      (qstat),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    // decoupling queue
    cwlw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_wr_data),
        .rd      (q_pop),
        .rd_data (q_rd_data),
        .qstat   (qstat)
    );

    // back: byte serializer
    cwlw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_rd_data),
        .qstat        (qstat),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .last_of_item (last_of_item)
    );

    // queue status is consistent
    a_qstat_sane : assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty together");

    // a configuration transfer lands in the register
    a_cfg_write : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[2] == REG_IDX_LINE_WIDTH) |=> line_width_reg == $past(pwdata[11:0]))
        else $error("line_width write lost");

    // full only while the front holds an item and the queue is full
    a_full_src : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> qstat.full)
        else $error("full raised with room in the queue");

    // the queue is never read while empty
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !qstat.empty)
        else $error("queue read while empty");

endmodule

[bench/cwlw_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cwlw_checker
// Watches the code point, byte and register ports of the line wrapper. It
// keeps its own cell count and line width, turns every accepted code point
// into the bytes it should cause, and compares them with the bytes popped.
// ----------------------------------------------------------------------------
module cwlw_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [30:0] code_point,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_byte,
    input  logic        last_of_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding
);
    import cwlw_pkg::*;

    localparam logic [30:0] NEWLINE_CP = {23'd0, NEWLINE_BYTE};
    localparam int          MAX_PRINTED = 100;

    // one output byte as it should appear
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wrap_byte_t;

    // combining marks, low bound in the upper half, high bound in the lower
    localparam int RANGE_COUNT = 92;
    localparam logic [31:0] COMBINING_RANGES [RANGE_COUNT] = '{
        32'h0300034E, 32'h03600362, 32'h04830486, 32'h04880489,
        32'h059105A1, 32'h05A305B9, 32'h05BB05BD, 32'h05BF05BF,
        32'h05C105C2, 32'h05C405C4, 32'h064B0655, 32'h06700670,
        32'h06D606E4, 32'h06E706E8, 32'h06EA06ED, 32'h07110711,
        32'h0730074A, 32'h07A607B0, 32'h09010902, 32'h093C093C,
        32'h09410948, 32'h094D094D, 32'h09510954, 32'h09620963,
        32'h09810981, 32'h09BC09BC, 32'h09C109C4, 32'h09CD09CD,
        32'h09E209E3, 32'h0A020A02, 32'h0A3C0A3C, 32'h0A410A42,
        32'h0A470A48, 32'h0A4B0A4D, 32'h0A700A71, 32'h0A810A82,
        32'h0ABC0ABC, 32'h0AC10AC5, 32'h0AC70AC8, 32'h0ACD0ACD,
        32'h0B010B01, 32'h0B3C0B3C, 32'h0B3F0B3F, 32'h0B410B43,
        32'h0B4D0B4D, 32'h0B560B56, 32'h0B820B82, 32'h0BC00BC0,
        32'h0BCD0BCD, 32'h0C3E0C40, 32'h0C460C48, 32'h0C4A0C4D,
        32'h0C550C56, 32'h0CBF0CBF, 32'h0CC60CC6, 32'h0CCC0CCD,
        32'h0D410D43, 32'h0D4D0D4D, 32'h0DCA0DCA, 32'h0DD20DD4,
        32'h0DD60DD6, 32'h0E310E31, 32'h0E340E3A, 32'h0E470E4E,
        32'h0EB10EB1, 32'h0EB40EB9, 32'h0EBB0EBC, 32'h0EC80ECD,
        32'h0F180F19, 32'h0F350F35, 32'h0F370F37, 32'h0F390F39,
        32'h0F710F7E, 32'h0F800F84, 32'h0F860F87, 32'h0F900F97,
        32'h0F990FBC, 32'h0FC60FC6, 32'h102D1030, 32'h10321032,
        32'h10361037, 32'h10391039, 32'h10581059, 32'h17B717BD,
        32'h17C617C6, 32'h17C917D3, 32'h18A918A9, 32'h20D020E3,
        32'h302A302F, 32'h3099309A, 32'hFB1EFB1E, 32'hFE20FE23
    };

    logic [11:0]        cols_allowed;
    logic signed [15:0] cells_used;
    wrap_byte_t         byte_q [$];
    int                 printed;

    // one line per mismatch, quiet after the first hundred
    task automatic report_mismatch(input string what);
        fail_count++;
        if (printed < MAX_PRINTED)
        begin
            $display("%0t mismatch: %s", $time, what);
        end
        printed++;
    endtask

    // append one expected byte at the tail
    task automatic add_expected(input logic [7:0] data, input logic last);
        wrap_byte_t nb;
        nb.data = data;
        nb.last = last;
        byte_q  = {byte_q, nb};
    endtask

    // terminal width class of one code point
    function automatic logic [1:0] width_class(input logic [30:0] cp);
        int  i;
        logic wide;
        if (cp == 31'd0)
        begin
            return W_ZERO;
        end
        if (cp < 31'h20 || (cp >= 31'h7F && cp < 31'hA0))
        begin
            return W_NEG;
        end
        for (i = 0; i < RANGE_COUNT; i++)
        begin
            if (cp >= {15'd0, COMBINING_RANGES[i][31:16]} &&
                cp <= {15'd0, COMBINING_RANGES[i][15:0]})
            begin
                return W_ZERO;
            end
        end
        wide = (cp >= 31'h1100 && cp <= 31'h115F) ||
               (cp >= 31'h2E80 && cp <= 31'hA4CF &&
                cp != 31'h300A && cp != 31'h300B && cp != 31'h301A &&
                cp != 31'h301B && cp != 31'h303F) ||
               (cp >= 31'hAC00 && cp <= 31'hD7A3) ||
               (cp >= 31'hF900 && cp <= 31'hFAFF) ||
               (cp >= 31'hFE30 && cp <= 31'hFE6F) ||
               (cp >= 31'hFF00 && cp <= 31'hFF5F) ||
               (cp >= 31'hFFE0 && cp <= 31'hFFE6);
        return wide ? W_TWO : W_ONE;
    endfunction

    function automatic int cells_of(input logic [1:0] cls);
        case (cls)
            W_NEG:   return -1;
            W_ONE:   return 1;
            W_TWO:   return 2;
            default: return 0;
        endcase
    endfunction

    // advance the cell count and queue the bytes one code point causes
    task automatic predict_bytes(input logic [30:0] cp);
        int          sum;
        int          len;
        int          k;
        int          shift;
        logic [31:0] c;
        logic [7:0]  lead;
        logic [7:0]  b;
        c   = {1'b0, cp};
        sum = int'(cells_used) + cells_of(width_class(cp));
        if (sum > 32767)
        begin
            sum = 32767;
        end
        if (sum < -32768)
        begin
            sum = -32768;
        end
        if (cp == NEWLINE_CP)
        begin
            sum = 0;
        end
        // wrap before the character when the line is overfull
        if (sum > int'(cols_allowed))
        begin
            sum = 0;
            add_expected(NEWLINE_BYTE, 1'b0);
        end
        cells_used = 16'(sum);
        lead = 8'd0;
        if (c < 32'h80)
        begin
            len = 1;
        end
        else if (c < 32'h800)
        begin
            len  = 2;
            lead = LEAD_2;
        end
        else if (c < 32'h10000)
        begin
            len  = 3;
            lead = LEAD_3;
        end
        else if (c < 32'h200000)
        begin
            len  = 4;
            lead = LEAD_4;
        end
        else if (c < 32'h4000000)
        begin
            len  = 5;
            lead = LEAD_5;
        end
        else
        begin
            len  = 6;
            lead = LEAD_6;
        end
        for (k = 0; k < len; k++)
        begin
            shift = 6 * (len - 1 - k);
            if (len == 1)
            begin
                b = c[7:0];
            end
            else if (k == 0)
            begin
                b = 8'(32'(lead) + (c >> shift));
            end
            else
            begin
                b = 8'(32'(CONT_BYTE) + ((c >> shift) & 32'h3F));
            end
            add_expected(b, k == len - 1);
        end
    endtask

    // watch all three ports at every edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        wrap_byte_t want;
        if (!rst_n)
        begin
            cols_allowed = LINE_WIDTH_RESET;
            cells_used   = 16'sd0;
            byte_q.delete();
            fail_count   = 0;
            printed      = 0;
            outstanding <= 0;
        end
        else
        begin
            // register read-back
            if (psel && penable && !pwrite && pready && paddr[2] == REG_IDX_LINE_WIDTH)
            begin
                if (prdata !== {20'd0, cols_allowed})
                begin
                    report_mismatch($sformatf("line_width read %0h, want %0h",
                                              prdata, cols_allowed));
                end
            end
            // register write; other indexes leave the width alone
            if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_LINE_WIDTH)
            begin
                cols_allowed = pwdata[11:0];
            end
            // byte transfer against the oldest expectation
            if (pop && !empty)
            begin
                if (byte_q.size() == 0)
                begin
                    report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                              out_byte, last_of_item));
                end
                else
                begin
                    want = byte_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  out_byte, want.data));
                    end
                    if (last_of_item !== want.last)
                    begin
                        report_mismatch($sformatf("last_of_item %0b, want %0b on byte %02h",
                                                  last_of_item, want.last, want.data));
                    end
                end
            end
            // code point transfer
            if (push && !full)
            begin
                predict_bytes(code_point);
            end
            outstanding <= byte_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the cell-width line wrapper: edge code points of every width
// class and UTF-8 length, random text under several line widths, a long
// receiver hold-off that backs up the input, and a run of controls that
// drives the cell count negative. Checking is in cwlw_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import cwlw_pkg::*;

    localparam logic REG_IDX_SPARE   = 1'b1;
    localparam int   HOLD_OFF_CYCLES = 300;
    localparam int   DRAIN_CYCLES    = 20;
    localparam int   EDGE_COUNT      = 25;
    localparam logic [30:0] NEWLINE_CP = {23'd0, NEWLINE_BYTE};

    // boundaries of width classes and of encoding lengths
    localparam logic [30:0] EDGE_CPS [EDGE_COUNT] = '{
        31'h00, 31'h0A, 31'h1F, 31'h20, 31'h7E, 31'h7F, 31'h9F, 31'hA0,
        31'h7FF, 31'h800, 31'h0300, 31'h1100, 31'h115F, 31'h2E80, 31'h300A,
        31'h301B, 31'h303F, 31'hFFE6, 31'hFFFF, 31'h10000, 31'h1FFFFF,
        31'h200000, 31'h3FFFFFF, 31'h4000000, 31'h7FFFFFFF
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [30:0] code_point;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        last_of_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;

    logic        tx_gaps = 1'b0;
    logic        rx_stalls = 1'b0;
    logic        hold_off_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    utf8_cell_width_line_wrap_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .code_point   (code_point),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    cwlw_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .code_point   (code_point),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // control character that lowers the count
    function automatic logic [30:0] control_cp();
        case ($urandom_range(0, 2))
            0:       return 31'($urandom_range(1, 9));
            1:       return 31'($urandom_range(11, 31));
            default: return 31'($urandom_range(32'h7F, 32'h9F));
        endcase
    endfunction

    // character from the double-width blocks; parts of 3000-303F are narrow or zero width
    function automatic logic [30:0] wide_cp();
        case ($urandom_range(0, 7))
            0:       return 31'($urandom_range(32'h1100, 32'h115F));
            1:       return 31'($urandom_range(32'h3000, 32'h303F));
            2:       return 31'($urandom_range(32'h4E00, 32'h9FFF));
            3:       return 31'($urandom_range(32'hAC00, 32'hD7A3));
            4:       return 31'($urandom_range(32'hF900, 32'hFAFF));
            5:       return 31'($urandom_range(32'hFE30, 32'hFE6F));
            6:       return 31'($urandom_range(32'hFF00, 32'hFF5F));
            default: return 31'($urandom_range(32'hFFE0, 32'hFFE6));
        endcase
    endfunction

    // text-like mix of all width classes and encoding lengths
    function automatic logic [30:0] next_text_cp();
        int          pick;
        logic [31:0] mask;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            return 31'($urandom_range(32'h20, 32'h7E));
        end
        else if (pick < 45)
        begin
            return NEWLINE_CP;
        end
        else if (pick < 53)
        begin
            return control_cp();
        end
        else if (pick < 68)
        begin
            return wide_cp();
        end
        else if (pick < 76)
        begin
            case ($urandom_range(0, 3))
                0:       return 31'($urandom_range(32'h0300, 32'h034E));
                1:       return 31'($urandom_range(32'h0591, 32'h05A1));
                2:       return 31'($urandom_range(32'h20D0, 32'h20E3));
                default: return 31'($urandom_range(32'h302A, 32'h302F));
            endcase
        end
        else if (pick < 86)
        begin
            return 31'($urandom_range(32'h80, 32'hFFFF));
        end
        mask = (32'h1 << $urandom_range(1, 31)) - 32'h1;
        return 31'($urandom() & mask);
    endfunction

    // one code point transfer, with an optional idle gap first
    task automatic send_item(input logic [30:0] cp);
        if (tx_gaps && $urandom_range(0, 2) == 0)
        begin
            push <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        push       <= 1'b1;
        code_point <= cp;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    // stop offering and wait until every expected byte has gone out
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stalls, runs of steady pops, one long hold-off on request
    initial
    begin : rx_side
        int run;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (rx_stalls && $urandom_range(0, 2) == 0)
            begin
                pop <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                if (!rx_stalls)
                begin
                    run = 1;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    run = $urandom_range(40, 80);
                end
                else
                begin
                    run = $urandom_range(1, 8);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int i;
        push       <= 1'b0;
        code_point <= 31'd0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= 3'd0;
        pwdata     <= 32'd0;
        rst_n      <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width, then the edge code points
        apb_read(REG_IDX_LINE_WIDTH);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        for (i = 0; i < EDGE_COUNT; i++)
        begin
            send_item(EDGE_CPS[i]);
        end
        wait_drained();

        // a write to the spare index must not touch the width
        apb_write(REG_IDX_SPARE, 32'h0000_0003);
        apb_read(REG_IDX_LINE_WIDTH);
        for (i = 0; i < 50; i++)
        begin
            send_item(next_text_cp());
        end
        wait_drained();

        // zero width: every positive-width character that takes the count above zero wraps first
        apb_write(REG_IDX_LINE_WIDTH, 32'd0);
        apb_read(REG_IDX_LINE_WIDTH);
        for (i = 0; i < 30; i++)
        begin
            send_item(next_text_cp());
        end
        wait_drained();

        // widest line, upper data bits set; characters from the wide blocks back to back
        apb_write(REG_IDX_LINE_WIDTH, 32'hFFFF_FFFF);
        apb_read(REG_IDX_LINE_WIDTH);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        for (i = 0; i < 20; i++)
        begin
            send_item(wide_cp());
        end
        wait_drained();

        // narrow lines, with a long receiver hold-off in the middle
        apb_write(REG_IDX_LINE_WIDTH, $urandom_range(1, 20));
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        for (i = 0; i < 70; i++)
        begin
            if (i == 20)
            begin
                tx_gaps      = 1'b0;
                hold_off_req = 1'b1;
            end
            if (i == 55)
            begin
                tx_gaps = 1'b1;
            end
            send_item(next_text_cp());
        end
        wait_drained();

        // controls drive the count negative; it must not wrap
        apb_write(REG_IDX_LINE_WIDTH, 32'd0);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        for (i = 0; i < 20; i++)
        begin
            send_item(control_cp());
        end
        for (i = 0; i < 8; i++)
        begin
            send_item(31'($urandom_range(32'h21, 32'h7E)));
        end
        send_item(NEWLINE_CP);
        send_item(31'h41);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("PASS utf8_cell_width_line_wrap_top");
        end
        else
        begin
            $display("FAIL utf8_cell_width_line_wrap_top");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("FAIL utf8_cell_width_line_wrap_top");
        $finish;
    end

endmodule

[files.f]
rtl/cwlw_pkg.sv
rtl/cwlw_front.sv
rtl/cwlw_queue.sv
rtl/cwlw_back.sv
rtl/utf8_cell_width_line_wrap_top.sv
bench/cwlw_checker.sv
bench/tb_top.sv
